// ----- rtl/synth_voice_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared concurrent assertion forms used by the voice allocator checker.
// ----------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVALLOC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SVALLOC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/svalloc_pkg.sv -----
// ----------------------------------------------------------------------------
// Voice allocator package
// Command codes, group mode codes, field widths and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package svalloc_pkg;

  // Field widths of the request and result words
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned NOTE_W = 7;
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned OSC_W  = 4;

  // Stored note width; all ones marks a group with no note
  localparam int unsigned GNOTE_W = 8;
  localparam logic [GNOTE_W-1:0] NO_NOTE = 8'hFF;

  // Command codes (six and seven are unused)
  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE_ON      = 3'd0,
    CMD_NOTE_OFF     = 3'd1,
    CMD_ALL_OFF      = 3'd2,
    CMD_FIND_NOTE    = 3'd3,
    CMD_AGE_TICK     = 3'd4,
    CMD_RELEASE_DONE = 3'd5
  } cmd_t;

  // Group modes; code three is never written and counts as busy
  localparam int unsigned MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAYING   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASING = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_t;

  // Result word
  typedef struct packed {
    logic [OSC_W-1:0] osc_index;
    logic             found;
    logic             stolen;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/svalloc_if.sv -----
// ----------------------------------------------------------------------------
// Voice allocator channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface svalloc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [6:0] note;
  logic [2:0] group_sel;

  modport source (output valid, output cmd, output note, output group_sel, input ready);
  modport sink (input valid, input cmd, input note, input group_sel, output ready);
endinterface

interface svalloc_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] osc_index;
  logic       found;
  logic       stolen;

  modport source (output valid, output osc_index, output found, output stolen, input ready);
  modport sink (input valid, input osc_index, input found, input stolen, output ready);
endinterface

`default_nettype wire

// ----- rtl/svalloc_ram.sv -----
// ----------------------------------------------------------------------------
// Voice allocator RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module svalloc_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/svalloc_engine.sv -----
// ----------------------------------------------------------------------------
// Voice allocator scan engine
// Walks the group RAM once per request word, one group a cycle, and
// applies the command to each group, writing back the groups it changes.
// ----------------------------------------------------------------------------
`default_nettype none

module svalloc_engine #(
  parameter int unsigned NUM_GROUPS      = 8,
  parameter int unsigned VOICES_PER_NOTE = 2,
  parameter int unsigned AGE_BITS        = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request word
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [svalloc_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [svalloc_pkg::NOTE_W-1:0] in_note,
  input  wire logic [svalloc_pkg::SEL_W-1:0]  in_sel,
  // group RAM
  output logic                             rd_en,
  output logic [(NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1)-1:0] rd_addr,
  input  wire logic [svalloc_pkg::MODE_W+svalloc_pkg::GNOTE_W+AGE_BITS-1:0] rd_data,
  output logic                             wr_en,
  output logic [(NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1)-1:0] wr_addr,
  output logic [svalloc_pkg::MODE_W+svalloc_pkg::GNOTE_W+AGE_BITS-1:0] wr_data,
  // result word
  output logic                             res_valid,
  output svalloc_pkg::res_t                res,
  input  wire logic                        res_take
);

  import svalloc_pkg::*;

  localparam int unsigned GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned CW = $clog2(NUM_GROUPS + 1);
  localparam int unsigned PW = GW + OSC_W;
  localparam int unsigned SW = GW + SEL_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  state_t state, state_next;

  logic [CMD_W-1:0]    cmd_q;
  logic [NOTE_W-1:0]   note_q;
  logic [SEL_W-1:0]    sel_q;
  logic [CW-1:0]       rd_cnt, rd_cnt_next;
  logic [GW-1:0]       proc_idx, proc_idx_next;
  logic                proc_vld, proc_vld_next;
  logic [GW-1:0]       pick, pick_next;
  logic [AGE_BITS-1:0] oldest, oldest_next;
  logic                hit, hit_next;

  logic [MODE_W-1:0]   ent_mode;
  logic [GNOTE_W-1:0]  ent_note;
  logic [AGE_BITS-1:0] ent_age;
  logic [GNOTE_W-1:0]  note_ext;
  logic [PW-1:0]       osc_prod;
  logic                take_in;

  // Unpack the group entry read back from RAM
  assign ent_mode = rd_data[MODE_W+GNOTE_W+AGE_BITS-1 -: MODE_W];
  assign ent_note = rd_data[GNOTE_W+AGE_BITS-1 -: GNOTE_W];
  assign ent_age  = rd_data[AGE_BITS-1:0];
  assign note_ext = GNOTE_W'(note_q);

  assign take_in  = in_valid && in_ready;
  assign osc_prod = PW'(pick) * PW'(VOICES_PER_NOTE);

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld <= 1'b0;
      rd_cnt   <= '0;
      hit      <= 1'b0;
    end else begin
      proc_vld <= proc_vld_next;
      rd_cnt   <= rd_cnt_next;
      hit      <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      cmd_q  <= in_cmd;
      note_q <= in_note;
      sel_q  <= in_sel;
    end
    proc_idx <= proc_idx_next;
    pick     <= pick_next;
    oldest   <= oldest_next;
  end

  // Next state, scan control and per-group update
  always_comb begin
    state_next    = state;
    rd_cnt_next   = rd_cnt;
    proc_idx_next = proc_idx;
    proc_vld_next = 1'b0;
    pick_next     = pick;
    oldest_next   = oldest;
    hit_next      = hit;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = rd_cnt[GW-1:0];
    wr_en         = 1'b0;
    wr_addr       = proc_idx;
    wr_data       = rd_data;
    res_valid     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rd_cnt_next = '0;
          pick_next   = '0;
          oldest_next = '0;
          hit_next    = 1'b0;
          state_next  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read per group
        if (rd_cnt < CW'(NUM_GROUPS)) begin
          rd_en         = 1'b1;
          rd_cnt_next   = rd_cnt + CW'(1);
          proc_vld_next = 1'b1;
          proc_idx_next = rd_cnt[GW-1:0];
        end else if (!proc_vld) begin
          state_next = (cmd_q == CMD_NOTE_ON) ? ST_COMMIT : ST_DONE;
        end

        // apply the command to the group read last cycle
        if (proc_vld) begin
          unique case (cmd_q)
            CMD_NOTE_ON: begin
              if (!hit) begin
                if (ent_mode == MODE_IDLE) begin
                  hit_next  = 1'b1;
                  pick_next = proc_idx;
                end else if (ent_age > oldest) begin
                  oldest_next = ent_age;
                  pick_next   = proc_idx;
                end
              end
            end
            CMD_NOTE_OFF: begin
              if (ent_note == note_ext && ent_mode == MODE_PLAYING) begin
                wr_en   = 1'b1;
                wr_data = {MODE_RELEASING, ent_note, ent_age};
              end
            end
            CMD_ALL_OFF: begin
              wr_en   = 1'b1;
              wr_data = {MODE_RELEASING, ent_note, ent_age};
            end
            CMD_FIND_NOTE: begin
              if (!hit && ent_note == note_ext) begin
                hit_next  = 1'b1;
                pick_next = proc_idx;
              end
            end
            CMD_AGE_TICK: begin
              if (ent_mode != MODE_IDLE && ent_age != AGE_MAX) begin
                wr_en   = 1'b1;
                wr_data = {ent_mode, ent_note, ent_age + AGE_BITS'(1)};
              end
            end
            CMD_RELEASE_DONE: begin
              if (SW'(proc_idx) == SW'(sel_q) && ent_mode == MODE_RELEASING) begin
                wr_en   = 1'b1;
                wr_data = {MODE_IDLE, ent_note, ent_age};
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_COMMIT: begin
        // claim the chosen group for the new note
        wr_en      = 1'b1;
        wr_addr    = pick;
        wr_data    = {MODE_PLAYING, note_ext, AGE_BITS'(0)};
        state_next = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Build the result word
  always_comb begin
    res = '0;
    case (cmd_q)
      CMD_NOTE_ON: begin
        res.osc_index = osc_prod[OSC_W-1:0];
        res.stolen    = !hit;
      end
      CMD_FIND_NOTE: begin
        if (hit) begin
          res.osc_index = osc_prod[OSC_W-1:0];
          res.found     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/synth_voice_allocator.sv -----
// ----------------------------------------------------------------------------
// Synthesizer voice allocator
// Oldest-note stealing allocator of oscillator groups to notes.
// ----------------------------------------------------------------------------
// One request word is in work at a time. Each word walks all groups of the
// group RAM, one read a cycle on its single read port, with NUM_GROUPS =
// NUM_OSC / VOICES_PER_NOTE. The walk then drains the last read and closes.
// A note-on then writes the chosen group back before its result is offered.
// The engine holds its result until the output register is empty or being
// drained. The next request is taken in the cycle the result appears in the
// output register. A new request is taken while the previous result still
// sits in the output register. No clearing pass is needed after reset: a
// valid flag per group makes unwritten groups read as idle with no note and
// age zero.
`default_nettype none

module synth_voice_allocator #(
  parameter int unsigned NUM_OSC         = 16,
  parameter int unsigned VOICES_PER_NOTE = 2,
  parameter int unsigned AGE_BITS        = 16
) (
  input wire logic      clk,
  input wire logic      rst,
  svalloc_req_if.sink   req,
  svalloc_rsp_if.source rsp
);

  import svalloc_pkg::*;

  localparam int unsigned NUM_GROUPS =
    ((NUM_OSC / VOICES_PER_NOTE) > 0) ? (NUM_OSC / VOICES_PER_NOTE) : 1;
  localparam int unsigned GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned EW = MODE_W + GNOTE_W + AGE_BITS;
  localparam logic [EW-1:0] RESET_ENTRY = {MODE_IDLE, NO_NOTE, {AGE_BITS{1'b0}}};

  logic          rd_en, wr_en;
  logic [GW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data, ram_q, rd_data;
  logic [NUM_GROUPS-1:0] ent_vld;
  logic          rd_vld_q;
  logic          res_valid, res_take;
  res_t          res;
  logic          rsp_valid;
  res_t          rsp_word;

  svalloc_engine #(
    .NUM_GROUPS      (NUM_GROUPS),
    .VOICES_PER_NOTE (VOICES_PER_NOTE),
    .AGE_BITS        (AGE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_cmd    (req.cmd),
    .in_note   (req.note),
    .in_sel    (req.group_sel),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  svalloc_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_GROUPS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Track which groups have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (wr_en) begin
      ent_vld[wr_addr] <= 1'b1;
    end
  end

  // Sample the valid flag alongside the RAM read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_q <= ent_vld[rd_addr];
    end
  end

  assign rd_data = rd_vld_q ? ram_q : RESET_ENTRY;

  // Output register: load when empty or being drained
  assign res_take = res_valid && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp_word <= res;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.osc_index = rsp_word.osc_index;
  assign rsp.found     = rsp_word.found;
  assign rsp.stolen    = rsp_word.stolen;

endmodule

`default_nettype wire

// ----- rtl/svalloc_checker.sv -----
// ----------------------------------------------------------------------------
// Voice allocator checker
// Port-level assertions on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "synth_voice_allocator_macros.svh"

module svalloc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [3:0] rsp_osc_index,
  input wire logic       rsp_found,
  input wire logic       rsp_stolen
);

  // A stalled result word stays offered
  `SVALLOC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")

  // A stalled result word keeps its payload
  `SVALLOC_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_osc_index) && $stable(rsp_found) && $stable(rsp_stolen), "result payload changed while stalled")

  // One request word in work at a time
  `SVALLOC_ASSERT_NEXT(a_one_in_work, clk, rst, req_valid && req_ready, !req_ready, "request taken while another is in work")

  // A find hit and a steal never share a result word
  `SVALLOC_ASSERT_NOW(a_found_stolen, clk, rst, rsp_valid, !(rsp_found && rsp_stolen), "found and stolen both set")

endmodule

bind synth_voice_allocator svalloc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_osc_index (rsp.osc_index),
  .rsp_found     (rsp.found),
  .rsp_stolen    (rsp.stolen)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives request words into synth_voice_allocator and checks every result
// word against an in-bench model of the group table. The model tracks mode,
// stored note and age for each group. The run has a short directed opening,
// then random traffic under three idling mixes, the last of them starting
// with a long result stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import svalloc_pkg::*;

  localparam int unsigned NUM_OSC   = 16;
  localparam int unsigned VOICES    = 2;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned GROUPS    = NUM_OSC / VOICES;

  // Command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int unsigned STALL_LEN   = 300;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [NOTE_W-1:0] NOTE_POOL = 7'd60;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NOTE_W-1:0] note;
    logic [SEL_W-1:0]  sel;
  } req_word_t;

  logic clk;
  logic rst;

  svalloc_req_if req_ch ();
  svalloc_rsp_if rsp_ch ();

  synth_voice_allocator #(
    .NUM_OSC         (NUM_OSC),
    .VOICES_PER_NOTE (VOICES),
    .AGE_BITS        (AGE_W)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Group table as the bench sees it
  logic [MODE_W-1:0]  grp_mode [GROUPS];
  logic [GNOTE_W-1:0] grp_note [GROUPS];
  logic [AGE_W-1:0]   grp_age  [GROUPS];

  req_word_t request_backlog [$];
  res_t      outcomes_due [$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  logic        stall_trig;
  logic        stall_seen;
  int unsigned stall_left;
  logic        req_fire;
  int unsigned quiet_cycles;
  int unsigned words_in;
  int unsigned results_checked;
  int unsigned steals_seen;
  int unsigned finds_hit;
  int unsigned fail_count;

  // Apply one request word to the group table and return its result word
  function automatic res_t alloc_outcome(logic [CMD_W-1:0] cmd, logic [NOTE_W-1:0] nt,
                                         logic [SEL_W-1:0] sel);
    res_t             r;
    int unsigned      pick;
    logic [AGE_W-1:0] oldest;
    bit               have_idle;
    bit               hit;
    r = '0;
    case (cmd)
      CMD_NOTE_ON: begin
        pick = 0;
        oldest = '0;
        have_idle = 1'b0;
        // first idle group wins; otherwise strictly oldest, ties keep lower
        for (int g = 0; g < GROUPS; g++) begin
          if (!have_idle) begin
            if (grp_mode[g] == MODE_IDLE) begin
              pick = g;
              have_idle = 1'b1;
            end else if (grp_age[g] > oldest) begin
              oldest = grp_age[g];
              pick = g;
            end
          end
        end
        grp_note[pick] = {1'b0, nt};
        grp_mode[pick] = MODE_PLAYING;
        grp_age[pick] = '0;
        r.osc_index = OSC_W'(pick * VOICES);
        r.stolen = !have_idle;
      end
      CMD_NOTE_OFF: begin
        for (int g = 0; g < GROUPS; g++)
          if (grp_note[g] == {1'b0, nt} && grp_mode[g] == MODE_PLAYING)
            grp_mode[g] = MODE_RELEASING;
      end
      CMD_ALL_OFF: begin
        for (int g = 0; g < GROUPS; g++)
          grp_mode[g] = MODE_RELEASING;
      end
      CMD_FIND_NOTE: begin
        hit = 1'b0;
        // stored note survives the group going idle
        for (int g = 0; g < GROUPS; g++) begin
          if (!hit && grp_note[g] == {1'b0, nt}) begin
            r.osc_index = OSC_W'(g * VOICES);
            r.found = 1'b1;
            hit = 1'b1;
          end
        end
      end
      CMD_AGE_TICK: begin
        for (int g = 0; g < GROUPS; g++)
          if (grp_mode[g] != MODE_IDLE && grp_age[g] != '1)
            grp_age[g] = grp_age[g] + 1'b1;
      end
      CMD_RELEASE_DONE: begin
        if (int'(sel) < GROUPS && grp_mode[sel] == MODE_RELEASING)
          grp_mode[sel] = MODE_IDLE;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic push_req(logic [CMD_W-1:0] cmd, logic [NOTE_W-1:0] nt, logic [SEL_W-1:0] sel);
    req_word_t w;
    w.cmd = cmd;
    w.note = nt;
    w.sel = sel;
    request_backlog.push_back(w);
  endtask

  // Mostly notes from a small pool so note_off and find_note hit held notes
  function automatic req_word_t random_req();
    req_word_t   w;
    int unsigned roll;
    roll = $urandom_range(99);
    w.note = ($urandom_range(9) < 7) ? NOTE_POOL + NOTE_W'($urandom_range(7))
                                     : NOTE_W'($urandom_range(127));
    w.sel = SEL_W'($urandom_range(GROUPS - 1));
    if (roll < 30)       w.cmd = CMD_NOTE_ON;
    else if (roll < 45)  w.cmd = CMD_NOTE_OFF;
    else if (roll < 48)  w.cmd = CMD_ALL_OFF;
    else if (roll < 62)  w.cmd = CMD_FIND_NOTE;
    else if (roll < 82)  w.cmd = CMD_AGE_TICK;
    else if (roll < 97)  w.cmd = CMD_RELEASE_DONE;
    else if (roll < 99)  w.cmd = CMD_SPARE_6;
    else                 w.cmd = CMD_SPARE_7;
    return w;
  endfunction

  // Hold until every queued word is taken and every result has come back
  task automatic drain();
    while (request_backlog.size() != 0 || req_ch.valid) @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned count, int unsigned src_pct, int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (count) request_backlog.push_back(random_req());
    drain();
  endtask

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Request driver: advance to the next word once the current one is taken
  always @(negedge clk) begin
    req_word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.cmd <= '0;
      req_ch.note <= '0;
      req_ch.group_sel <= '0;
    end else if (!req_ch.valid || req_fire) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        w = request_backlog.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.cmd <= w.cmd;
        req_ch.note <= w.note;
        req_ch.group_sel <= w.sel;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random idling, or a long hold-off when triggered
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_seen <= 1'b0;
      stall_left <= 0;
    end else if (stall_trig != stall_seen) begin
      stall_seen <= stall_trig;
      stall_left <= STALL_LEN;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    res_t due;
    if (rst) begin
      req_fire <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        grp_mode[g] = MODE_IDLE;
        grp_note[g] = NO_NOTE;
        grp_age[g] = '0;
      end
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        outcomes_due.push_back(alloc_outcome(req_ch.cmd, req_ch.note, req_ch.group_sel));
        words_in++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (outcomes_due.size() == 0) begin
          $error("result word with nothing due: osc_index %0d found %0b stolen %0b",
                 rsp_ch.osc_index, rsp_ch.found, rsp_ch.stolen);
          fail_count++;
        end else begin
          due = outcomes_due.pop_front();
          results_checked++;
          if (due.stolen) steals_seen++;
          if (due.found) finds_hit++;
          if (rsp_ch.osc_index !== due.osc_index) begin
            $error("osc_index: expected %0d, got %0d", due.osc_index, rsp_ch.osc_index);
            fail_count++;
          end
          if (rsp_ch.found !== due.found) begin
            $error("found: expected %0b, got %0b", due.found, rsp_ch.found);
            fail_count++;
          end
          if (rsp_ch.stolen !== due.stolen) begin
            $error("stolen: expected %0b, got %0b", due.stolen, rsp_ch.stolen);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.note = '0;
    req_ch.group_sel = '0;
    rsp_ch.ready = 1'b0;
    stall_trig = 1'b0;
    src_idle_pct = 19;
    snk_idle_pct = 61;
    words_in = 0;
    results_checked = 0;
    steals_seen = 0;
    finds_hit = 0;
    fail_count = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed opening
    push_req(CMD_FIND_NOTE, 7'd127, 3'd0);      // empty table: no match
    push_req(CMD_NOTE_ON, 7'd0, 3'd0);
    push_req(CMD_NOTE_ON, 7'd127, 3'd0);
    push_req(CMD_FIND_NOTE, 7'd127, 3'd0);
    push_req(CMD_FIND_NOTE, 7'd0, 3'd0);
    push_req(CMD_NOTE_OFF, 7'd0, 3'd0);
    push_req(CMD_RELEASE_DONE, 7'd0, 3'd0);
    push_req(CMD_RELEASE_DONE, 7'd0, 3'd1);     // group still playing: ignored
    push_req(CMD_FIND_NOTE, 7'd0, 3'd0);        // idle group keeps its note
    push_req(CMD_NOTE_ON, 7'd64, 3'd0);
    push_req(CMD_AGE_TICK, 7'd0, 3'd0);
    push_req(CMD_SPARE_6, 7'h55, 3'd7);
    push_req(CMD_SPARE_7, 7'h2A, 3'd2);
    for (int g = 2; g < GROUPS; g++) begin
      push_req(CMD_NOTE_ON, NOTE_W'(10 + g), 3'd0);
      push_req(CMD_AGE_TICK, 7'd0, 3'd0);
    end
    push_req(CMD_NOTE_ON, 7'd100, 3'd0);        // every group busy: steal
    push_req(CMD_ALL_OFF, 7'd0, 3'd0);
    push_req(CMD_RELEASE_DONE, 7'd0, 3'd7);
    push_req(CMD_NOTE_ON, 7'd50, 3'd0);
    push_req(CMD_FIND_NOTE, 7'd50, 3'd0);
    drain();

    // Random traffic under three idling mixes
    random_phase(180, 19, 61);
    random_phase(180, 61, 19);
    // hold results off while requests keep coming
    stall_trig = 1'b1;
    random_phase(190, 0, 0);
    repeat (30) @(posedge clk);

    $display("Covered %0d request words: directed cases, three idling mixes and a %0d-cycle",
             words_in, STALL_LEN);
    $display("result stall; %0d results, %0d steals, %0d finds hit",
             results_checked, steals_seen, finds_hit);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
